// File: hw/rtl/ordered_int_set_table_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the ordered integer set table
// Shared property shorthands, clocked on clock and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ORDERED_INT_SET_TABLE_ASSERT_SVH
`define ORDERED_INT_SET_TABLE_ASSERT_SVH

// Condition holds at every edge out of reset.
`define OIST_ASSERT_ALWAYS(lbl, cond, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (cond)) else $error(msg);

// Antecedent at one edge implies consequent at the next.
`define OIST_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: hw/rtl/oist_pkg.sv
// ----------------------------------------------------------------------------
// Ordered integer set table package
// Sizes, operation codes and the item and cell link structs.
// ----------------------------------------------------------------------------
package oist_pkg;

   localparam int CAPACITY = 16;
   localparam int CNT_W    = $clog2(CAPACITY + 1);

   typedef enum logic [1:0] {
      OP_LOOKUP = 2'd0,
      OP_ADD    = 2'd1,
      OP_REMOVE = 2'd2,
      OP_CLEAR  = 2'd3
   } op_type;

   typedef struct packed {
      op_type             op;
      logic signed [31:0] value;
   } oist_req_type;

   typedef struct packed {
      logic       hit;
      logic       full_error;
      logic [4:0] count;
      logic       empty_res;
   } oist_rsp_type;

   // Broadcast to every cell for the item being accepted.
   typedef struct packed {
      logic               do_add;
      logic               do_remove;
      logic               do_clear;
      logic signed [31:0] value;
   } oist_cmd_type;

   // What one cell shows its neighbours.
   typedef struct packed {
      logic               occ;    // cell holds a value
      logic               seen;   // match here or in any cell before
      logic signed [31:0] entry;
   } oist_link_type;

endpackage

// File: hw/rtl/oist_cell.sv
// ----------------------------------------------------------------------------
// Ordered integer set table cell
// One slot: compares against the broadcast value, appends, clears, or takes the
// entry of its right-hand neighbour when a removal closes a gap.
// ----------------------------------------------------------------------------
module oist_cell (
   input  logic                   clock,
   input  logic                   reset,
   input  oist_pkg::oist_cmd_type cmd_i,
   input  oist_pkg::oist_link_type prev_i,
   input  oist_pkg::oist_link_type next_i,
   output oist_pkg::oist_link_type link_o
);
   import oist_pkg::*;

   logic               occ_ff, occ_in;
   logic signed [31:0] entry_ff, entry_in;
   logic               match;
   logic               seen;

   assign match = occ_ff && (entry_ff == cmd_i.value);
   assign seen  = prev_i.seen || match;

   always_comb begin
      occ_in   = occ_ff;
      entry_in = entry_ff;
      if (cmd_i.do_clear) begin
         occ_in = 1'b0;
      end else if (cmd_i.do_remove && seen) begin
         // shift down: the last held cell picks up an empty neighbour
         occ_in   = next_i.occ;
         entry_in = next_i.entry;
      end else if (cmd_i.do_add && !occ_ff && prev_i.occ) begin
         occ_in   = 1'b1;
         entry_in = cmd_i.value;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         occ_ff <= 1'b0;
      end else begin
         occ_ff <= occ_in;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign link_o.occ   = occ_ff;
   assign link_o.seen  = seen;
   assign link_o.entry = entry_ff;

endmodule

// File: hw/rtl/ordered_int_set_table.sv
// ----------------------------------------------------------------------------
// Ordered integer set table
// Set of distinct 32-bit values kept in insertion order in a chain of cells.
// ----------------------------------------------------------------------------
// An item (op, value) looks up, adds, removes or clears; each item gives
// exactly one result item with hit, full_error, count and empty_res. One item
// is taken per clock: every cell compares against the value at once, the
// first-match flag ripples along the chain, and a removal shifts all later
// cells down by one place in the same cycle. The result sits in an output
// register, so a new item is taken while the previous result is taken, and
// only a stalled result (rsp_ready low) holds req_ready low. rsp_valid rises
// in the cycle after acceptance. Adding a value not held to a full table
// drops it and sets full_error. No clearing pass is needed at reset.
// ----------------------------------------------------------------------------
`include "ordered_int_set_table_assert.svh"

module ordered_int_set_table (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  oist_pkg::oist_req_type req_data,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output oist_pkg::oist_rsp_type rsp_data
);
   import oist_pkg::*;

   logic             rsp_valid_ff, rsp_valid_in;
   oist_rsp_type     rsp_data_ff, rsp_data_in;
   logic [CNT_W-1:0] count_ff, count_in;

   oist_cmd_type     cmd;
   oist_link_type    link_w [CAPACITY];
   logic [CAPACITY-1:0] occ_vec;

   logic accept;
   logic found;
   logic is_full;
   logic add_ok;

   // Input is free whenever the output register is empty or being drained.
   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;

   // The last cell's seen flag says whether any held cell matched.
   assign found   = link_w[CAPACITY-1].seen;
   assign is_full = (count_ff == CNT_W'(CAPACITY));
   assign add_ok  = (req_data.op == OP_ADD) && !found && !is_full;

   assign cmd.do_add    = accept && add_ok;
   assign cmd.do_remove = accept && (req_data.op == OP_REMOVE);
   assign cmd.do_clear  = accept && (req_data.op == OP_CLEAR);
   assign cmd.value     = req_data.value;

   // Chain of cells; the left edge looks occupied so cell 0 takes the first add.
   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      oist_link_type prev_l;
      oist_link_type next_l;

      if (i == 0) begin : g_first
         assign prev_l.occ   = 1'b1;
         assign prev_l.seen  = 1'b0;
         assign prev_l.entry = '0;
      end else begin : g_mid
         assign prev_l = link_w[i-1];
      end

      if (i == CAPACITY - 1) begin : g_last
         assign next_l.occ   = 1'b0;
         assign next_l.seen  = 1'b0;
         assign next_l.entry = '0;
      end else begin : g_inner
         assign next_l = link_w[i+1];
      end

      oist_cell u_cell (
         .clock  (clock),
         .reset  (reset),
         .cmd_i  (cmd),
         .prev_i (prev_l),
         .next_i (next_l),
         .link_o (link_w[i])
      );

      assign occ_vec[i] = link_w[i].occ;
   end

   // Count update, result formation for the accepted item and output drain.
   always_comb begin
      count_in     = count_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;

      if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      if (accept) begin
         rsp_data_in.hit        = 1'b0;
         rsp_data_in.full_error = 1'b0;
         case (req_data.op)
            OP_LOOKUP: begin
               rsp_data_in.hit = found;
            end
            OP_ADD: begin
               rsp_data_in.hit        = add_ok;
               rsp_data_in.full_error = !found && is_full;
               if (add_ok) begin
                  count_in = count_ff + CNT_W'(1);
               end
            end
            OP_REMOVE: begin
               rsp_data_in.hit = found;
               if (found) begin
                  count_in = count_ff - CNT_W'(1);
               end
            end
            OP_CLEAR: begin
               count_in = '0;
            end
            default: begin
               count_in = count_ff;
            end
         endcase
         rsp_data_in.count     = 5'(count_in);
         rsp_data_in.empty_res = (count_in == '0);
         rsp_valid_in          = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         count_ff     <= '0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         count_ff     <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // Occupied cells stay packed from cell 0 and agree with the count.
   `OIST_ASSERT_ALWAYS(a_packed, (occ_vec & (occ_vec + CAPACITY'(1))) == '0, "cells not packed")
   `OIST_ASSERT_ALWAYS(a_count_occ, $countones(occ_vec) == int'(count_ff), "count mismatch")
   `OIST_ASSERT_ALWAYS(a_count_cap, count_ff <= CNT_W'(CAPACITY), "count over capacity")
   `OIST_ASSERT_NEXT(a_clear, cmd.do_clear, count_ff == '0 && occ_vec == '0, "clear left entries")
   `OIST_ASSERT_NEXT(a_add, cmd.do_add, count_ff == $past(count_ff) + CNT_W'(1), "add lost")

endmodule

// File: tb/sv/ordered_int_set_table_check.sv
// ----------------------------------------------------------------------------
// Ordered integer set table checker
// Watches both channels, keeps its own copy of the set and compares results.
// ----------------------------------------------------------------------------
module ordered_int_set_table_check (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  logic                   req_ready,
   input  oist_pkg::oist_req_type req_data,
   input  logic                   rsp_valid,
   input  logic                   rsp_ready,
   input  oist_pkg::oist_rsp_type rsp_data,
   output int                     mismatch_count,
   output int                     outstanding
);
   import oist_pkg::*;

   localparam int PRINT_CAP = 40;

   // Shadow of the table: live entries sit below held_total, packed in order.
   logic [31:0]  held_values [CAPACITY];
   int           held_total = 0;

   oist_rsp_type awaited_results [$];
   oist_rsp_type want;
   oist_rsp_type got;
   oist_rsp_type predicted;
   int           fails = 0;
   int           results_seen = 0;

   task automatic report_mismatch(input string what, input int got_v, input int want_v);
      if (fails < PRINT_CAP) begin
         $display("mismatch in result %0d, %s: got %0d, want %0d",
                  results_seen, what, got_v, want_v);
      end
      fails++;
   endtask

   task automatic predict_set_op(input oist_req_type item, output oist_rsp_type res);
      int          slot;
      logic [31:0] v;
      logic        hit;
      logic        full;
      v    = item.value;
      hit  = 1'b0;
      full = 1'b0;
      slot = held_total;
      for (int i = 0; i < held_total; i++) begin
         if (slot == held_total && held_values[i] == v) slot = i;
      end
      case (item.op)
         OP_LOOKUP: begin
            hit = (slot < held_total);
         end
         OP_ADD: begin
            if (slot < held_total) begin
               hit = 1'b0;
            end else if (held_total >= CAPACITY) begin
               full = 1'b1;
            end else begin
               held_values[held_total] = v;
               held_total++;
               hit = 1'b1;
            end
         end
         OP_REMOVE: begin
            if (slot < held_total) begin
               for (int k = slot; k + 1 < held_total; k++) held_values[k] = held_values[k + 1];
               held_total--;
               hit = 1'b1;
            end
         end
         default: begin
            held_total = 0;
         end
      endcase
      res.hit        = hit;
      res.full_error = full;
      res.count      = 5'(held_total);
      res.empty_res  = (held_total == 0);
   endtask

   always @(posedge clock) begin
      if (reset) begin
         awaited_results.delete();
         held_total = 0;
      end else begin
         // Result first: it always belongs to an item taken at an earlier edge.
         if (rsp_valid && rsp_ready) begin
            got = rsp_data;
            if (awaited_results.size() == 0) begin
               report_mismatch("result with nothing awaited", 1, 0);
            end else begin
               want = awaited_results.pop_front();
               if (got.hit !== want.hit)
                  report_mismatch("hit", int'(got.hit), int'(want.hit));
               if (got.full_error !== want.full_error)
                  report_mismatch("full_error", int'(got.full_error),
                                  int'(want.full_error));
               if (got.count !== want.count)
                  report_mismatch("count", int'(got.count), int'(want.count));
               if (got.empty_res !== want.empty_res)
                  report_mismatch("empty_res", int'(got.empty_res),
                                  int'(want.empty_res));
            end
            results_seen++;
         end
         if (req_valid && req_ready) begin
            predict_set_op(req_data, predicted);
            awaited_results.push_back(predicted);
         end
      end
      mismatch_count <= fails;
      outstanding    <= awaited_results.size();
   end

endmodule

// File: tb/sv/ordered_int_set_table_test.sv
// ----------------------------------------------------------------------------
// Ordered integer set table testbench
// Directed and random look-up, add, remove and clear items under varied idling.
// ----------------------------------------------------------------------------
// A short directed run covers the field extremes, every op, duplicate adds,
// removes of absent values, removal shifts and the full-table refusal. Four
// random phases follow, each with its own idling mix and value pool; pools
// are kept small so the table fills, hits are common and full errors occur.
// The checker beside the block predicts every result and counts mismatches.
// ----------------------------------------------------------------------------
module ordered_int_set_table_test;
   import oist_pkg::*;

   localparam int ITEMS_PER_PHASE = 388;
   localparam int QUIET_LIMIT     = 2000;  // cycles with no item moving
   localparam int HOLD_OFF_CYCLES = 60;    // long receiver stall
   localparam int MAX_GAP         = 40;    // cap on one sender gap

   logic         clock     = 1'b0;
   logic         reset     = 1'b1;
   logic         req_valid = 1'b0;
   logic         req_ready;
   oist_req_type req_data  = '0;
   logic         rsp_valid;
   logic         rsp_ready = 1'b0;
   oist_rsp_type rsp_data;

   int mismatch_count;
   int outstanding;

   // Idling knobs; the percentages change only between phases, hold_ask within one.
   int send_idle_pct = 0;
   int rsp_stall_pct = 0;
   int hold_ask      = 0;   // bumped to ask the sink for one long stall
   int quiet_cycles  = 0;

   // Random values mostly come from a small pool so items hit held entries.
   logic [31:0] pool_base = '0;
   int          pool_size = 20;

   ordered_int_set_table dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   ordered_int_set_table_check set_check (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_data       (req_data),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_data       (rsp_data),
      .mismatch_count (mismatch_count),
      .outstanding    (outstanding)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Result sink: random stalls, plus one long hold-off on request.
   initial begin : result_sink
      int hold_seen;
      int hold_left;
      hold_seen = 0;
      hold_left = 0;
      forever begin
         @(posedge clock);
         if (hold_ask != hold_seen) begin
            hold_seen = hold_ask;
            hold_left = HOLD_OFF_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= ($urandom_range(99) >= rsp_stall_pct);
         end
      end
   end

   // Watchdog: too long with nothing accepted on either side means a hang.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles < QUIET_LIMIT) begin
         quiet_cycles <= quiet_cycles + 1;
      end else begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   function automatic oist_req_type set_op(input op_type o, input logic [31:0] v);
      oist_req_type item;
      item.op    = o;
      item.value = v;
      return item;
   endfunction

   // Add-heavy mix so the table fills; clear kept rare so it stays full a while.
   function automatic oist_req_type random_set_op();
      int          pick;
      op_type      o;
      logic [31:0] v;
      pick = $urandom_range(99);
      if (pick < 45)      o = OP_ADD;
      else if (pick < 67) o = OP_REMOVE;
      else if (pick < 98) o = OP_LOOKUP;
      else                o = OP_CLEAR;
      pick = $urandom_range(99);
      if (pick < 82) begin
         v = pool_base ^ ($urandom_range(pool_size - 1) * 32'h9E37_79B9);
      end else if (pick < 86) begin
         case ($urandom_range(3))
            0:       v = 32'h8000_0000;
            1:       v = 32'h7FFF_FFFF;
            2:       v = 32'h0000_0000;
            default: v = 32'hFFFF_FFFF;
         endcase
      end else begin
         v = $urandom();
      end
      return set_op(o, v);
   endfunction

   // Offer one item, hold it until taken, then maybe idle a while.
   task automatic send_item(input oist_req_type item);
      int gap;
      req_valid <= 1'b1;
      req_data  <= item;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      gap = 0;
      while (gap < MAX_GAP && $urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
         gap++;
      end
   endtask

   // Stop offering and wait for every awaited result to come back.
   task automatic drain();
      req_valid <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
   endtask

   initial begin
      int phase;
      int k;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // directed: empty table, extremes, duplicates, shifts, full refusal
      send_item(set_op(OP_LOOKUP, 32'h0000_0000));
      send_item(set_op(OP_REMOVE, 32'h0000_0005));   // absent
      send_item(set_op(OP_ADD,    32'h8000_0000));
      send_item(set_op(OP_ADD,    32'h7FFF_FFFF));
      send_item(set_op(OP_ADD,    32'h8000_0000));   // already held
      send_item(set_op(OP_REMOVE, 32'h8000_0000));   // first entry, rest shift
      send_item(set_op(OP_CLEAR,  32'h7FFF_FFFF));
      send_item(set_op(OP_ADD,    32'h0000_0000));
      send_item(set_op(OP_ADD,    32'hFFFF_FFFF));
      send_item(set_op(OP_ADD,    32'h8000_0000));
      send_item(set_op(OP_ADD,    32'h7FFF_FFFF));
      send_item(set_op(OP_ADD,    32'hAAAA_AAAA));
      send_item(set_op(OP_ADD,    32'h5555_5555));
      for (k = 1; k <= CAPACITY - 6; k++) send_item(set_op(OP_ADD, 32'h0001_0003 * k));
      send_item(set_op(OP_ADD,    32'h1234_5678));   // new value, table full
      send_item(set_op(OP_ADD,    32'h7FFF_FFFF));   // held value, table full
      send_item(set_op(OP_REMOVE, 32'h5555_5555));   // middle of a full table
      send_item(set_op(OP_REMOVE, 32'h0001_0003 * (CAPACITY - 6)));   // last entry
      drain();

      // random phases: none, sender idle, receiver stalls, both
      for (phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin send_idle_pct <= 0;  rsp_stall_pct <= 0;  pool_size = 20; end
            1: begin send_idle_pct <= 86; rsp_stall_pct <= 0;  pool_size = 12; end
            2: begin send_idle_pct <= 0;  rsp_stall_pct <= 86; pool_size = 24; end
            default: begin send_idle_pct <= 28; rsp_stall_pct <= 28; pool_size = 18; end
         endcase
         pool_base = $urandom();
         for (k = 0; k < ITEMS_PER_PHASE; k++) begin
            // long sink stall while items keep coming, so the input backs up
            if (k == ITEMS_PER_PHASE / 3 && (phase == 0 || phase == 3))
               hold_ask <= hold_ask + 1;
            send_item(random_set_op());
         end
         drain();
      end

      repeat (4) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
